// ===== rtl/pdds_pkg.sv =====
// ----------------------------------------------------------------------------
// pdds_pkg
// Types, codes and fixed-point helpers shared by the porous drag source block.
// ----------------------------------------------------------------------------
package pdds_pkg;

	localparam int unsigned NUM_COMP = 9;

	typedef enum logic [1:0] {
		MODE_COMPUTE   = 2'd0,
		MODE_LOAD_LIN  = 2'd1,
		MODE_LOAD_INER = 2'd2,
		MODE_UNUSED    = 2'd3
	} mode_t;

	typedef struct packed {
		logic [1:0]         mode;
		logic [9:0]         slot_index;
		logic [3:0]         component;
		logic signed [31:0] coeff_value;
		logic [30:0]        viscosity;
		logic [30:0]        density;
		logic [30:0]        volume;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_z;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] diag_add;
		logic signed [31:0] source_sub_x;
		logic signed [31:0] source_sub_y;
		logic signed [31:0] source_sub_z;
	} res_t;

	// saturate a wide signed value to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
		logic signed [66:0] hi;
		logic signed [66:0] lo;
		hi = 67'sd2147483647;
		lo = -67'sd2147483648;
		if (v > hi)
			sat32 = 32'sh7fffffff;
		else if (v < lo)
			sat32 = 32'sh80000000;
		else
			sat32 = v[31:0];
	endfunction

	// round a Q32.32 product to Q16.16, ties toward plus infinity, not saturated
	function automatic logic signed [48:0] qround(input logic signed [64:0] p);
		logic signed [64:0] b;
		b = p + 65'sd32768;
		qround = b[64:16];
	endfunction

endpackage

// ===== rtl/pdds_ram.sv =====
// ----------------------------------------------------------------------------
// pdds_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pdds_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/pdds_sqrt.sv =====
// ----------------------------------------------------------------------------
// pdds_sqrt
// Pipelined floor square root of a 66-bit value, two result bits per stage,
// 17 stages. The radicand is an unsigned sum of three squares.
// ----------------------------------------------------------------------------
module pdds_sqrt #(
	parameter int TAGW = 8
) (
	input  logic            clk,
	input  logic [65:0]     rad,
	input  logic [TAGW-1:0] tag_in,
	output logic [32:0]     root,
	output logic [TAGW-1:0] tag_out
);

	localparam int STAGES = 17;

	logic [67:0]     rem_s  [STAGES+1];
	logic [33:0]     res_s  [STAGES+1];
	logic [67:0]     rad_s  [STAGES+1];
	logic [TAGW-1:0] tag_s  [STAGES+1];

	assign rem_s[0] = '0;
	assign res_s[0] = '0;
	// padded to 34 bit pairs so every stage takes exactly two
	assign rad_s[0] = {2'b00, rad};
	assign tag_s[0] = tag_in;

	// restoring method, two bits of radicand per result bit; pairs 33 downto 0
	for (genvar g = 0; g < STAGES; g++) begin : g_stage
		logic [67:0] r;
		logic [33:0] q;
		logic [67:0] trial;
		always_comb begin
			r = rem_s[g];
			q = res_s[g];
			trial = '0;
			for (int k = 0; k < 2; k++) begin
				r = {r[65:0], rad_s[g][67 - 2 * (2 * g + k) -: 2]};
				trial = {32'd0, q, 2'b01};
				if (r >= trial) begin
					r = r - trial;
					q = {q[32:0], 1'b1};
				end else begin
					q = {q[32:0], 1'b0};
				end
			end
		end
		always_ff @(posedge clk) begin
			rem_s[g+1] <= r;
			res_s[g+1] <= q;
			rad_s[g+1] <= rad_s[g];
			tag_s[g+1] <= tag_s[g];
		end
	end

	assign root    = res_s[STAGES][32:0];
	assign tag_out = tag_s[STAGES];

	// the root of a 66-bit radicand never reaches the top bit
	logic unused_top;
	assign unused_top = res_s[STAGES][33];

endmodule

// ===== rtl/porous_drag_diag_source.sv =====
// ----------------------------------------------------------------------------
// porous_drag_diag_source
// Darcy-Forchheimer porosity drag per cell, fully pipelined.
// ----------------------------------------------------------------------------
// One item enters per cycle (busy is never raised); a compute item gives its
// result on result/done after it passes through the input register stage at
// the accepting edge, one stage for the sum of squares, the 17-stage square
// root and six multiply/round/saturate stages. Loads write the coefficient
// memories at the accepting edge and give no result. The receiver cannot
// stall, so there is no back pressure; the memories are not cleared after
// reset and must be loaded before use.
module porous_drag_diag_source #(
	parameter int MAX_SLOTS = 1024
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  pdds_pkg::cmd_t  cmd,
	output logic            done,
	output pdds_pkg::res_t  result
);

	localparam int DEPTH = MAX_SLOTS * 9;
	localparam int AW    = $clog2(DEPTH);
	localparam int TAGW  = 1 + 31 + 31 + 31 + 96 + 1;

	assign busy = 1'b0;

	// ---------------- stage 1: decode, memory address, squares ----------------
	logic        slot_ok, comp_ok;
	logic [AW-1:0] base_addr;
	assign slot_ok   = 32'(cmd.slot_index) < 32'(MAX_SLOTS);
	assign comp_ok   = cmd.component <= 4'd8;
	assign base_addr = AW'(32'(cmd.slot_index) * 9);

	logic          we_lin, we_in;
	logic [AW-1:0] waddr;
	logic [31:0]   wdata;
	always_comb begin
		we_lin = start && slot_ok && comp_ok
			&& cmd.mode == pdds_pkg::MODE_LOAD_LIN;
		we_in  = start && slot_ok && comp_ok
			&& cmd.mode == pdds_pkg::MODE_LOAD_INER;
		waddr  = base_addr + AW'(cmd.component);
		wdata  = cmd.coeff_value;
	end

	logic [31:0] lin_rd [9];
	logic [31:0] in_rd  [9];
	// nine banks per tensor, one per component, so a cell reads all at once
	for (genvar k = 0; k < 9; k++) begin : g_bank
		localparam int BD = MAX_SLOTS;
		localparam int BW = (BD > 1) ? $clog2(BD) : 1;
		logic [BW-1:0] ra, wa;
		logic wk;
		assign wa = BW'(cmd.slot_index);
		assign ra = BW'(cmd.slot_index);
		assign wk = (4'(k) == cmd.component);
		pdds_ram #(.WIDTH(32), .DEPTH(BD)) u_lin (
			.clk(clk), .we(we_lin && wk), .waddr(wa), .wdata(wdata),
			.raddr(ra), .rdata(lin_rd[k]));
		pdds_ram #(.WIDTH(32), .DEPTH(BD)) u_in (
			.clk(clk), .we(we_in && wk), .waddr(wa), .wdata(wdata),
			.raddr(ra), .rdata(in_rd[k]));
	end
	logic unused_addr;
	assign unused_addr = ^waddr;

	logic [63:0] sqx_s1, sqy_s1, sqz_s1;
	logic [TAGW-1:0] tag_s1;
	logic [31:0] ax, ay, az;
	always_comb begin
		ax = cmd.vel_x[31] ? 32'(-cmd.vel_x) : cmd.vel_x;
		ay = cmd.vel_y[31] ? 32'(-cmd.vel_y) : cmd.vel_y;
		az = cmd.vel_z[31] ? 32'(-cmd.vel_z) : cmd.vel_z;
	end
	logic v_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else
			v_s1 <= start && cmd.mode == pdds_pkg::MODE_COMPUTE;
	end
	always_ff @(posedge clk) begin
		sqx_s1 <= 64'(ax) * 64'(ax);
		sqy_s1 <= 64'(ay) * 64'(ay);
		sqz_s1 <= 64'(az) * 64'(az);
		tag_s1 <= {slot_ok, cmd.viscosity, cmd.density, cmd.volume,
			cmd.vel_x, cmd.vel_y, cmd.vel_z, 1'b0};
	end

	// coefficients are held in a delay line alongside the root pipeline
	localparam int CW = 9 * 64;
	logic [CW-1:0] coef_s2;
	always_ff @(posedge clk) begin
		for (int k = 0; k < 9; k++)
			coef_s2[k*64 +: 64] <= {lin_rd[k], in_rd[k]};
	end

	logic [65:0]     rad_s2;
	logic [TAGW-1:0] tag_s2;
	logic            v_s2;
	always_ff @(posedge clk) begin
		rad_s2 <= 66'(sqx_s1) + 66'(sqy_s1) + 66'(sqz_s1);
		tag_s2 <= {tag_s1[TAGW-1:1], v_s1};
	end
	assign v_s2 = tag_s2[0];

	logic [32:0]     root_s3;
	logic [TAGW-1:0] tag_s3;
	pdds_sqrt #(.TAGW(TAGW)) u_sqrt (
		.clk(clk), .rad(rad_s2), .tag_in(tag_s2), .root(root_s3), .tag_out(tag_s3));

	localparam int SQL = 17;
	logic [CW-1:0] coef_dl [SQL+1];
	assign coef_dl[0] = coef_s2;
	for (genvar d = 0; d < SQL; d++) begin : g_cdl
		always_ff @(posedge clk) coef_dl[d+1] <= coef_dl[d];
	end

	logic v_s1_dly_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1_dly_q <= 1'b0;
		else
			v_s1_dly_q <= v_s1;
	end

	// reset-cleared valid shift alongside the tag (tag valid is not reset)
	logic [SQL-1:0] vq;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vq <= '0;
		else
			vq <= {vq[SQL-2:0], v_s2 & v_s1_dly_q};
	end

	pdds_core u_core (
		.clk(clk), .arst_n(arst_n), .vld(vq[SQL-1] & tag_s3[0]), .root(root_s3),
		.tag(tag_s3[TAGW-1:1]), .coef(coef_dl[SQL]), .done(done), .result(result));

endmodule

// ===== rtl/pdds_core.sv =====
// ----------------------------------------------------------------------------
// pdds_core
// Drag tensor, trace, tensor-velocity product and volume scaling, pipelined.
// ----------------------------------------------------------------------------
module pdds_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            vld,
	input  logic [32:0]     root,
	input  logic [189:0]    tag,
	input  logic [575:0]    coef,
	output logic            done,
	output pdds_pkg::res_t  result
);

	logic        slot_ok;
	logic [30:0] mu, rho, vol;
	logic signed [31:0] u [3];
	assign {slot_ok, mu, rho, vol, u[0], u[1], u[2]} = tag;

	logic [5:0] v_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_q <= '0;
		else
			v_q <= {v_q[4:0], vld};
	end
	assign done = v_q[5];

	// c1: magnitude saturate, rho*|U|, mu*D products
	logic signed [31:0] mag;
	assign mag = (root[32] || root[31]) ? 32'sh7fffffff : $signed(root[31:0]);
	logic signed [64:0] rp_c1;
	logic signed [64:0] md_c1 [9];
	logic signed [31:0] f_c1 [9];
	logic [30:0] vol_c1;
	logic signed [31:0] u_c1 [3];
	always_ff @(posedge clk) begin
		rp_c1 <= $signed({34'd0, rho}) * 65'(mag);
		for (int k = 0; k < 9; k++) begin
			md_c1[k] <= $signed({34'd0, mu})
				* 65'(slot_ok ? $signed(coef[k*64+32 +: 32]) : 32'sd0);
			f_c1[k]  <= slot_ok ? $signed(coef[k*64 +: 32]) : 32'sd0;
		end
		vol_c1 <= vol;
		u_c1 <= u;
	end

	// c2: r*F products
	logic signed [31:0] r_c2;
	assign r_c2 = pdds_pkg::sat32(67'(pdds_pkg::qround(rp_c1)));
	logic signed [64:0] rf_c2 [9];
	logic signed [48:0] mdr_c2 [9];
	logic [30:0] vol_c2;
	logic signed [31:0] u_c2 [3];
	always_ff @(posedge clk) begin
		for (int k = 0; k < 9; k++) begin
			rf_c2[k]  <= 65'(r_c2) * 65'(f_c1[k]);
			mdr_c2[k] <= pdds_pkg::qround(md_c1[k]);
		end
		vol_c2 <= vol_c1;
		u_c2 <= u_c1;
	end

	// c3: Cd, trace
	logic signed [31:0] cd [9];
	always_comb begin
		for (int k = 0; k < 9; k++)
			cd[k] = pdds_pkg::sat32(67'(mdr_c2[k]) + 67'(pdds_pkg::qround(rf_c2[k])));
	end
	logic signed [31:0] cd_c3 [9];
	logic signed [31:0] tr_c3;
	logic [30:0] vol_c3;
	logic signed [31:0] u_c3 [3];
	always_ff @(posedge clk) begin
		cd_c3  <= cd;
		tr_c3  <= pdds_pkg::sat32(67'(cd[0]) + 67'(cd[4]) + 67'(cd[8]));
		vol_c3 <= vol_c2;
		u_c3   <= u_c2;
	end

	// c4: (Cd - t*I) . U products
	logic signed [64:0] pe_c4 [9];
	logic signed [31:0] tr_c4;
	logic [30:0] vol_c4;
	logic signed [31:0] e;
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				pe_c4[i*3+j] <= 65'((i == j)
					? pdds_pkg::sat32(67'(cd_c3[i*3+j]) - 67'(tr_c3))
					: cd_c3[i*3+j]) * 65'(u_c3[j]);
			end
		tr_c4  <= tr_c3;
		vol_c4 <= vol_c3;
	end
	assign e = '0;

	// c5: row sums, volume products
	logic signed [64:0] pv_c5 [4];
	always_ff @(posedge clk) begin
		pv_c5[0] <= $signed({34'd0, vol_c4}) * 65'(tr_c4);
		for (int i = 0; i < 3; i++)
			pv_c5[i+1] <= $signed({34'd0, vol_c4}) * 65'(pdds_pkg::sat32(
				67'(pdds_pkg::qround(pe_c4[i*3])) + 67'(pdds_pkg::qround(pe_c4[i*3+1]))
				+ 67'(pdds_pkg::qround(pe_c4[i*3+2])) + 67'(e)));
	end

	// c6: round and saturate
	always_ff @(posedge clk) begin
		result.diag_add     <= pdds_pkg::sat32(67'(pdds_pkg::qround(pv_c5[0])));
		result.source_sub_x <= pdds_pkg::sat32(67'(pdds_pkg::qround(pv_c5[1])));
		result.source_sub_y <= pdds_pkg::sat32(67'(pdds_pkg::qround(pv_c5[2])));
		result.source_sub_z <= pdds_pkg::sat32(67'(pdds_pkg::qround(pv_c5[3])));
	end

endmodule

// ===== rtl/pdds_checker.sv =====
// ----------------------------------------------------------------------------
// pdds_checker
// Port-level checks for the porous drag source block, bound to the top level.
// ----------------------------------------------------------------------------
module pdds_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_no_done_after_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> !done)
		else $error("result right after reset");

	a_done_needs_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 25))
		else $error("result with no transfer before it");

endmodule

bind porous_drag_diag_source pdds_checker u_pdds_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done));
